>>> hw/rtl/msgd_pkg.sv
// Shared constants, types and helpers for the minibatch SGD core.
`default_nettype none
package msgd_pkg;

  localparam int unsigned NumCoefs = 8;
  localparam int unsigned NumFeat  = NumCoefs - 1;
  localparam int unsigned IdxW     = $clog2(NumCoefs);
  localparam int unsigned FeatIdxW = $clog2(NumFeat);

  // Configuration register indexes.
  localparam logic [1:0] CFG_FEATURE_COUNT = 2'd0;
  localparam logic [1:0] CFG_BATCH_SIZE    = 2'd1;
  localparam logic [1:0] CFG_LEARNING_RATE = 2'd2;
  localparam logic [1:0] CFG_EPOCH_NUMBER  = 2'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  localparam logic [34:0] STEP_CAP = 35'h4_0000_0000;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_DOT_MUL,
    OP_DOT_ACC,
    OP_RES,
    OP_WS_MUL,
    OP_WS_ACC,
    OP_DIV_LD,
    OP_DIV_STEP,
    OP_SQ_MUL,
    OP_SQ_ADD,
    OP_ST_MUL0,
    OP_ST_MUL1,
    OP_ST_UPD,
    OP_NORM_LD,
    OP_SQRT_STEP,
    OP_NORM_FIN,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IdxW-1:0]  idx;
  } ctl_t;

  typedef struct packed {
    logic             is_target;
    logic             batch_full;
    logic             out_free;
    logic [IdxW-1:0]  feat_n;
  } sts_t;

  // Effective feature count: zero counts as one.
  function automatic logic [IdxW-1:0] feat_eff(input logic [2:0] fc);
    logic [IdxW-1:0] f;
    f = (fc == 3'd0) ? IdxW'(1) : IdxW'(fc);
    return f;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/msgd_ctrl.sv
// Sequencer that steps the datapath through rows, batch closes and reports.
`default_nettype none
module msgd_ctrl
  import msgd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  sts_t      sts_i,
  output ctl_t      ctl_o
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DOT_MUL  = 5'd1;
  localparam logic [4:0] S_DOT_ACC  = 5'd2;
  localparam logic [4:0] S_RES      = 5'd3;
  localparam logic [4:0] S_WS_MUL   = 5'd4;
  localparam logic [4:0] S_WS_ACC   = 5'd5;
  localparam logic [4:0] S_CHK      = 5'd6;
  localparam logic [4:0] S_DIV_LD   = 5'd7;
  localparam logic [4:0] S_DIV      = 5'd8;
  localparam logic [4:0] S_SQ_MUL   = 5'd9;
  localparam logic [4:0] S_SQ_ADD   = 5'd10;
  localparam logic [4:0] S_ST0      = 5'd11;
  localparam logic [4:0] S_ST1      = 5'd12;
  localparam logic [4:0] S_ST_UPD   = 5'd13;
  localparam logic [4:0] S_NORM_LD  = 5'd14;
  localparam logic [4:0] S_SQRT     = 5'd15;
  localparam logic [4:0] S_NORM_FIN = 5'd16;
  localparam logic [4:0] S_EMIT     = 5'd17;

  localparam logic [6:0] DIV_ITERS  = 7'd63;
  localparam logic [6:0] SQRT_ITERS = 7'd31;

  logic [4:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [6:0]      cnt_q, cnt_d;
  logic [IdxW-1:0] idx_inc;

  assign idx_inc    = idx_q + IdxW'(1);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    ctl_o.op   = OP_NONE;
    ctl_o.idx  = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.op = OP_ACCEPT;
          if (sts_i.is_target) begin
            idx_d   = '0;
            state_d = S_DOT_MUL;
          end
        end
      end
      S_DOT_MUL: begin
        ctl_o.op = OP_DOT_MUL;
        state_d  = S_DOT_ACC;
      end
      S_DOT_ACC: begin
        ctl_o.op = OP_DOT_ACC;
        idx_d    = idx_inc;
        state_d  = (idx_inc == sts_i.feat_n) ? S_RES : S_DOT_MUL;
      end
      S_RES: begin
        ctl_o.op = OP_RES;
        idx_d    = '0;
        state_d  = S_WS_MUL;
      end
      S_WS_MUL: begin
        ctl_o.op = OP_WS_MUL;
        state_d  = S_WS_ACC;
      end
      S_WS_ACC: begin
        ctl_o.op = OP_WS_ACC;
        idx_d    = idx_inc;
        state_d  = (idx_inc == sts_i.feat_n) ? S_CHK : S_WS_MUL;
      end
      S_CHK: begin
        idx_d   = '0;
        state_d = sts_i.batch_full ? S_DIV_LD : S_IDLE;
      end
      S_DIV_LD: begin
        ctl_o.op = OP_DIV_LD;
        cnt_d    = DIV_ITERS;
        state_d  = S_DIV;
      end
      S_DIV: begin
        ctl_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q - 7'd1;
        if (cnt_q == '0) begin
          state_d = S_SQ_MUL;
        end
      end
      S_SQ_MUL: begin
        ctl_o.op = OP_SQ_MUL;
        state_d  = S_SQ_ADD;
      end
      S_SQ_ADD: begin
        ctl_o.op = OP_SQ_ADD;
        state_d  = S_ST0;
      end
      S_ST0: begin
        ctl_o.op = OP_ST_MUL0;
        state_d  = S_ST1;
      end
      S_ST1: begin
        ctl_o.op = OP_ST_MUL1;
        state_d  = S_ST_UPD;
      end
      S_ST_UPD: begin
        ctl_o.op = OP_ST_UPD;
        idx_d    = idx_inc;
        state_d  = (idx_q == sts_i.feat_n) ? S_NORM_LD : S_DIV_LD;
      end
      S_NORM_LD: begin
        ctl_o.op = OP_NORM_LD;
        cnt_d    = SQRT_ITERS;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        ctl_o.op = OP_SQRT_STEP;
        cnt_d    = cnt_q - 7'd1;
        if (cnt_q == '0) begin
          state_d = S_NORM_FIN;
        end
      end
      S_NORM_FIN: begin
        ctl_o.op = OP_NORM_FIN;
        idx_d    = '0;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          ctl_o.op = OP_EMIT;
          idx_d    = idx_inc;
          if (idx_q == sts_i.feat_n) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/msgd_dpath.sv
// Datapath: coefficient and row storage, shared multiplier, divider and root unit.
`default_nettype none
module msgd_dpath
  import msgd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  ctl_t             ctl_i,
  output sts_t             sts_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [20:0] cfg_data_i,
  input  wire logic        cmd_i,
  input  wire logic [2:0]  column_i,
  input  wire logic [31:0] value_i,
  input  wire logic        last_row_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      epoch_label_o,
  output logic [15:0]      batch_index_o,
  output logic [31:0]      gradient_norm_o,
  output logic [2:0]       coef_index_o,
  output logic [31:0]      coef_value_o,
  output logic             last_item_o
);

  // Configuration.
  logic [2:0]  fc_q;
  logic [15:0] bsz_q;
  logic [20:0] lr_q;
  logic [15:0] epoch_q;

  // Model state.
  logic signed [31:0] coef_q [NumCoefs];
  logic signed [31:0] feat_q [NumFeat];
  logic signed [63:0] ws_q   [NumFeat];
  logic signed [63:0] rsum_q;
  logic [15:0]        rows_q;
  logic [15:0]        bcnt_q;

  // Working registers.
  logic signed [31:0] val_q;
  logic               last_q;
  logic signed [51:0] acc_q;
  logic signed [31:0] r_q;
  logic signed [65:0] prod_q;
  logic signed [65:0] stacc_q;
  logic [63:0]        num_q;
  logic [15:0]        rem_q;
  logic [63:0]        gmag_q;
  logic               gneg_q;
  logic [63:0]        sq_sum_q;
  logic               nsat_q;
  logic [63:0]        sq_n_q;
  logic [63:0]        root_q;
  logic [63:0]        bit_q;
  logic [31:0]        norm_q;
  logic [15:0]        bidx_q;
  logic               out_valid_q;

  logic [IdxW-1:0]     f_n;
  logic [FeatIdxW-1:0] fidx;
  logic [FeatIdxW-1:0] widx;
  logic [IdxW-1:0]     cidx_p1;
  logic [15:0]         bsz_eff;

  assign f_n     = feat_eff(fc_q);
  assign fidx    = FeatIdxW'(ctl_i.idx);
  assign widx    = FeatIdxW'(ctl_i.idx - IdxW'(1));
  assign cidx_p1 = ctl_i.idx + IdxW'(1);
  assign bsz_eff = (bsz_q == '0) ? 16'd1 : bsz_q;

  assign sts_o.is_target  = (cmd_i == CMD_DATA) && (IdxW'(column_i) == f_n);
  assign sts_o.batch_full = (rows_q >= bsz_eff) || last_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.feat_n     = f_n;

  // Shared multiplier operands.
  logic signed [32:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl_i.op)
      OP_DOT_MUL: begin
        mul_a = 33'(coef_q[cidx_p1]);
        mul_b = 33'(feat_q[fidx]);
      end
      OP_WS_MUL: begin
        mul_a = 33'(r_q);
        mul_b = 33'(feat_q[fidx]);
      end
      OP_SQ_MUL: begin
        mul_a = {1'b0, gmag_q[31:0]};
        mul_b = {1'b0, gmag_q[31:0]};
      end
      OP_ST_MUL0: begin
        mul_a = {12'd0, lr_q};
        mul_b = {7'd0, gmag_q[25:0]};
      end
      OP_ST_MUL1: begin
        mul_a = {12'd0, lr_q};
        mul_b = {8'd0, gmag_q[50:26]};
      end
      default: begin
      end
    endcase
  end

  // Residual with saturation.
  logic signed [52:0] diff;
  logic signed [31:0] r_sat;
  assign diff  = 53'(val_q) - 53'(acc_q);
  assign r_sat = (diff > 53'sd2147483647)  ? 32'sh7FFF_FFFF :
                 (diff < -53'sd2147483648) ? 32'sh8000_0000 : diff[31:0];

  // Gradient magnitude setup.
  logic signed [63:0] s_sel;
  logic [63:0]        s_mag;
  assign s_sel = (ctl_i.idx == '0) ? rsum_q : ws_q[widx];
  assign s_mag = s_sel[63] ? (64'd0 - s_sel) : s_sel;

  // Restoring divider step.
  logic [16:0] dv_t;
  logic        dv_ge;
  assign dv_t  = {rem_q, num_q[63]};
  assign dv_ge = dv_t >= {1'b0, rows_q};

  // Square accumulation.
  logic [64:0] sq_add;
  assign sq_add = {1'b0, sq_sum_q} + {1'b0, prod_q[63:0]};

  // Square root step.
  logic [63:0] rt_try;
  logic        rt_ge;
  assign rt_try = root_q + bit_q;
  assign rt_ge  = sq_n_q >= rt_try;

  // Coefficient step.
  logic [72:0]        st_total;
  logic [56:0]        st_sh;
  logic [34:0]        step;
  logic signed [36:0] nb;
  logic signed [31:0] nb_sat;
  logic signed [31:0] coef_k;
  assign coef_k   = coef_q[ctl_i.idx];
  assign st_total = 73'(stacc_q[47:0]) + {prod_q[46:0], 26'd0};
  assign st_sh    = st_total[72:16];
  assign step     = (((lr_q != '0) && (gmag_q[63:51] != '0)) || (st_sh > 57'(STEP_CAP)))
                    ? STEP_CAP : st_sh[34:0];
  assign nb       = gneg_q ? (37'(coef_k) + 37'(step)) : (37'(coef_k) - 37'(step));
  assign nb_sat   = (nb > 37'sd2147483647)  ? 32'sh7FFF_FFFF :
                    (nb < -37'sd2147483648) ? 32'sh8000_0000 : nb[31:0];

  logic [15:0] bcnt_inc;
  assign bcnt_inc = (bcnt_q != 16'hFFFF) ? (bcnt_q + 16'd1) : bcnt_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q    <= 3'd1;
      bsz_q   <= 16'd1;
      lr_q    <= 21'd655;
      epoch_q <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FEATURE_COUNT: fc_q    <= cfg_data_i[2:0];
        CFG_BATCH_SIZE:    bsz_q   <= cfg_data_i[15:0];
        CFG_LEARNING_RATE: lr_q    <= cfg_data_i;
        CFG_EPOCH_NUMBER:  epoch_q <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // Architectural state and control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCoefs; i++) begin
        coef_q[i] <= '0;
      end
      for (int i = 0; i < NumFeat; i++) begin
        ws_q[i] <= '0;
      end
      rsum_q      <= '0;
      rows_q      <= '0;
      bcnt_q      <= '0;
      last_q      <= 1'b0;
      nsat_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (ctl_i.op)
        OP_ACCEPT: begin
          if (cmd_i == CMD_LOAD) begin
            coef_q[column_i] <= value_i;
          end else if (sts_o.is_target) begin
            last_q <= last_row_i;
          end
        end
        OP_RES: begin
          rsum_q <= rsum_q + 64'(r_sat);
          rows_q <= rows_q + 16'd1;
        end
        OP_WS_ACC: begin
          ws_q[fidx] <= ws_q[fidx] + 64'($signed(prod_q[63:16]));
        end
        OP_DIV_LD: begin
          if (ctl_i.idx == '0) begin
            nsat_q <= 1'b0;
          end
        end
        OP_SQ_ADD: begin
          if ((gmag_q[63:32] != '0) || sq_add[64]) begin
            nsat_q <= 1'b1;
          end
        end
        OP_ST_UPD: begin
          coef_q[ctl_i.idx] <= nb_sat;
        end
        OP_NORM_LD: begin
          bcnt_q <= bcnt_inc;
        end
        OP_NORM_FIN: begin
          rsum_q <= '0;
          rows_q <= '0;
          for (int i = 0; i < NumFeat; i++) begin
            ws_q[i] <= '0;
          end
        end
        OP_EMIT: begin
          if ((ctl_i.idx == f_n) && last_q) begin
            bcnt_q <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_DOT_MUL, OP_WS_MUL, OP_SQ_MUL, OP_ST_MUL0: begin
        prod_q <= mul_a * mul_b;
      end
      OP_ST_MUL1: begin
        stacc_q <= prod_q;
        prod_q  <= mul_a * mul_b;
      end
      default: begin
      end
    endcase
    case (ctl_i.op)
      OP_ACCEPT: begin
        if ((cmd_i == CMD_DATA) && (IdxW'(column_i) < f_n)) begin
          feat_q[FeatIdxW'(column_i)] <= value_i;
        end
        if (sts_o.is_target) begin
          val_q <= value_i;
          acc_q <= 52'(coef_q[0]);
        end
      end
      OP_DOT_ACC: begin
        acc_q <= acc_q + 52'($signed(prod_q[63:16]));
      end
      OP_RES: begin
        r_q <= r_sat;
      end
      OP_DIV_LD: begin
        num_q  <= {s_mag[62:0], 1'b0};
        rem_q  <= '0;
        gneg_q <= !s_sel[63] && (s_sel != '0);
        if (ctl_i.idx == '0) begin
          sq_sum_q <= '0;
        end
      end
      OP_DIV_STEP: begin
        num_q  <= {num_q[62:0], 1'b0};
        rem_q  <= dv_ge ? 16'(dv_t - {1'b0, rows_q}) : dv_t[15:0];
        gmag_q <= {gmag_q[62:0], dv_ge};
      end
      OP_SQ_ADD: begin
        if ((gmag_q[63:32] == '0) && !sq_add[64]) begin
          sq_sum_q <= sq_add[63:0];
        end
      end
      OP_NORM_LD: begin
        sq_n_q <= sq_sum_q;
        root_q <= '0;
        bit_q  <= 64'h4000_0000_0000_0000;
        bidx_q <= bcnt_inc;
      end
      OP_SQRT_STEP: begin
        if (rt_ge) begin
          sq_n_q <= sq_n_q - rt_try;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_NORM_FIN: begin
        norm_q <= nsat_q ? 32'hFFFF_FFFF : root_q[31:0];
      end
      OP_EMIT: begin
        epoch_label_o   <= epoch_q;
        batch_index_o   <= bidx_q;
        gradient_norm_o <= norm_q;
        coef_index_o    <= 3'(ctl_i.idx);
        coef_value_o    <= coef_q[ctl_i.idx];
        last_item_o     <= (ctl_i.idx == f_n);
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  // The remainder never reaches the divisor during a division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_DIV_STEP) |-> (rem_q < rows_q))
    else $error("divider remainder out of range");

  // A batch close leaves the row count and residual sum cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_NORM_FIN) |=> ((rows_q == '0) && (rsum_q == '0)))
    else $error("batch accumulators not cleared");

  // A reported coefficient never lies beyond the feature count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (IdxW'(coef_index_o) <= f_n))
    else $error("coefficient index beyond feature count");

endmodule
`default_nettype wire

>>> hw/rtl/minibatch_sgd_linear_regression_core.sv
// Top level of the minibatch SGD linear regression core.
//
//   channel | direction | handshake                | payload
//   input   | in        | in_valid_i / in_ready_o  | cmd, column, value, last_row
//   result  | out       | out_valid_o / out_ready_i| epoch, batch, norm, coef, last
//   config  | in        | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// A coefficient load or feature item is accepted straight from idle; a target item runs
// the dot product and weighted sums through the one shared 33x33 multiplier.
// A batch close runs a bit-serial divide, a square and a step update per coefficient,
// then a square root; F+1 result items then leave one per cycle while out_ready_i holds.
// Reset is asynchronous; the core is ready for items right after it.
// A result waits in the output register while the next item is accepted.
`default_nettype none
module minibatch_sgd_linear_regression_core
  import msgd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [20:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [2:0]  column_i,
  input  wire logic [31:0] value_i,
  input  wire logic        last_row_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      epoch_label_o,
  output logic [15:0]      batch_index_o,
  output logic [31:0]      gradient_norm_o,
  output logic [2:0]       coef_index_o,
  output logic [31:0]      coef_value_o,
  output logic             last_item_o
);

  ctl_t ctl;
  sts_t sts;

  msgd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  msgd_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd_i),
    .column_i        (column_i),
    .value_i         (value_i),
    .last_row_i      (last_row_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .epoch_label_o   (epoch_label_o),
    .batch_index_o   (batch_index_o),
    .gradient_norm_o (gradient_norm_o),
    .coef_index_o    (coef_index_o),
    .coef_value_o    (coef_value_o),
    .last_item_o     (last_item_o)
  );

endmodule
`default_nettype wire
